/* src/mpt_pkg.sv */
// ---------------------------------------------------------------------------
// mpt_pkg: shared types and codes for the MAC presence table
// Entry layout, request and status codes, sequencer states.
// ---------------------------------------------------------------------------
package mpt_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 64;
	localparam int SLOT_W              = 6;
	localparam int MAC_W               = 48;
	localparam int IP_W                = 32;
	localparam int TIME_W              = 32;
	localparam int ARP_W               = 2;

	localparam logic [ARP_W-1:0] ARP_FULL = 2'd3;

	typedef enum logic [2:0] {
		REQ_TRAFFIC  = 3'd0,
		REQ_ARP      = 3'd1,
		REQ_REGISTER = 3'd2,
		REQ_FLUSH    = 3'd3,
		REQ_READ     = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		STS_UPDATED     = 3'd0,
		STS_INSERTED    = 3'd1,
		STS_NOT_LEARNED = 3'd2,
		STS_FULL        = 3'd3,
		STS_DONE        = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [ARP_W-1:0]  arp;
		logic [TIME_W-1:0] last;
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
	} entry_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] idx;
		logic              vld;
		entry_t            ent;
	} result_t;

endpackage

/* src/mac_presence_table_unit.sv */
// ---------------------------------------------------------------------------
// mac_presence_table_unit: table of client devices keyed by MAC address
// Fully associative store, one slot compared per cycle by a shared comparator.
// ---------------------------------------------------------------------------
// Usage:
//  s_axis: one request item per handshake. tuser = request kind (traffic,
//    ARP, register, flush, read); tdata = MAC, IP, time, read slot.
//  m_axis: one result item per request. tuser = status; tdata = slot index,
//    slot valid and the slot contents.
//  cfg: single-bit manual_mode write, always ready; write only when idle.
// Sequencing: traffic/ARP/register items scan the slots through the entry RAM,
//  one slot per cycle on one 48-bit comparator, up to the first match or,
//  when none matches, through the last slot. Read of a valid slot passes
//  through the S_READ state; read of an empty slot, flush and unknown kinds
//  go straight to S_EMIT.
// Flow: one item in the sequencer; s_axis_tready is high only while it
//  is idle, which starts when the result moves to the output register, so a
//  new item is accepted only after the last result has left the sequencer.
// Reset: all valid marks clear at once (flip-flops), table empty, manual mode
//  off; no clearing pass. Entry RAM contents are never reported unless valid.
// Stall: the result sits in an output register; a new request is accepted
//  while it waits, and a second result waits in the sequencer until taken.
// ---------------------------------------------------------------------------
module mac_presence_table_unit #(
	parameter int TABLE_DEPTH = mpt_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	// request channel
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,  // mac_addr[47:0], ip_addr[79:48],
	                                    // now_seconds[111:80], read_slot[117:112]
	input  logic [2:0]   s_axis_tuser,  // req_type[2:0]
	// result channel
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // slot_index[5:0], slot_valid[6],
	                                    // slot_mac[54:7], slot_ip[86:55],
	                                    // slot_last_alive[118:87],
	                                    // slot_arp_alive[120:119]
	output logic [2:0]   m_axis_tuser,  // status[2:0]
	// configuration
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data       // manual_mode
);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);

	// input fields
	logic [47:0] in_mac;
	logic [31:0] in_ip;
	logic [31:0] in_now;
	logic [5:0]  in_slot;
	logic        s_accept;

	assign in_mac   = s_axis_tdata[47:0];
	assign in_ip    = s_axis_tdata[79:48];
	assign in_now   = s_axis_tdata[111:80];
	assign in_slot  = s_axis_tdata[117:112];
	assign s_accept = s_axis_tvalid && s_axis_tready;

	// control state
	mpt_pkg::state_t        state_q, state_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic                   vld_s1;
	logic                   free_found_q, free_found_d;
	logic                   out_vld_q;
	logic                   manual_q;
	logic [TABLE_DEPTH-1:0] valid_q;

	// payload
	logic [2:0]             req_q;
	logic [47:0]            mac_q;
	logic [31:0]            ip_q;
	logic [31:0]            now_q;
	logic [5:0]             rs_q;
	logic [IDX_W-1:0]       addr_s1;
	logic [IDX_W-1:0]       free_idx_q, free_idx_d;
	mpt_pkg::result_t       res_q, res_d;
	mpt_pkg::result_t       out_q;

	// RAM port signals
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	mpt_pkg::entry_t        wr_data;
	logic [IDX_W-1:0]       rd_addr;
	mpt_pkg::entry_t        rd_data;

	// sequencer strobes
	logic                   res_load;
	logic                   set_valid;
	logic                   clr_all;
	logic                   issue;
	logic [IDX_W-1:0]       issue_idx;
	logic                   hit;
	logic                   emit_go;
	logic                   rs_in_range;

	mpt_entry_ram #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == mpt_pkg::S_IDLE);

	assign issue     = (state_q == mpt_pkg::S_SCAN) && (cnt_q != CNT_END);
	assign issue_idx = cnt_q[IDX_W-1:0];
	// shared comparator: entry read last cycle against the request MAC
	assign hit       = (state_q == mpt_pkg::S_SCAN) && vld_s1 && valid_q[addr_s1]
	                   && (rd_data.mac == mac_q);
	assign emit_go   = !out_vld_q || m_axis_tready;
	assign rs_in_range = (32'(in_slot) < 32'(TABLE_DEPTH));

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		free_found_d = free_found_q;
		free_idx_d   = free_idx_q;
		res_d        = res_q;
		res_load     = 1'b0;
		set_valid    = 1'b0;
		clr_all      = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = addr_s1;
		wr_data      = rd_data;
		rd_addr      = issue_idx;

		unique case (state_q)
			mpt_pkg::S_IDLE: begin
				rd_addr = IDX_W'(in_slot);
				if (s_accept) begin
					res_load   = 1'b1;
					res_d      = '0;
					res_d.status = mpt_pkg::STS_DONE;
					state_d    = mpt_pkg::S_EMIT;
					case (s_axis_tuser)
						mpt_pkg::REQ_FLUSH: begin
							clr_all = 1'b1;
						end
						mpt_pkg::REQ_READ: begin
							res_d.idx = in_slot;
							if (rs_in_range && valid_q[IDX_W'(in_slot)]) begin
								state_d = mpt_pkg::S_READ;
							end
						end
						mpt_pkg::REQ_TRAFFIC, mpt_pkg::REQ_ARP,
						mpt_pkg::REQ_REGISTER: begin
							state_d      = mpt_pkg::S_SCAN;
							cnt_d        = '0;
							free_found_d = 1'b0;
						end
						default: ;  // unknown kinds: empty done result
					endcase
				end
			end

			mpt_pkg::S_READ: begin
				res_load   = 1'b1;
				res_d.status = mpt_pkg::STS_DONE;
				res_d.idx  = rs_q;
				res_d.vld  = 1'b1;
				res_d.ent  = rd_data;
				state_d    = mpt_pkg::S_EMIT;
			end

			mpt_pkg::S_SCAN: begin
				if (issue) begin
					cnt_d = cnt_q + CNT_W'(1);
					if (!free_found_q && !valid_q[issue_idx]) begin
						free_found_d = 1'b1;
						free_idx_d   = issue_idx;
					end
				end
				res_d = '0;
				if (hit) begin
					// refresh the matched entry in place
					wr_data = rd_data;
					if (req_q == mpt_pkg::REQ_TRAFFIC) begin
						wr_data.last = now_q;
						wr_data.ip   = ip_q;
					end else if (req_q == mpt_pkg::REQ_ARP) begin
						wr_data.arp = mpt_pkg::ARP_FULL;
						wr_data.ip  = ip_q;
					end
					wr_en        = 1'b1;
					wr_addr      = addr_s1;
					res_load     = 1'b1;
					res_d.status = mpt_pkg::STS_UPDATED;
					res_d.idx    = 6'(addr_s1);
					res_d.vld    = 1'b1;
					res_d.ent    = wr_data;
					state_d      = mpt_pkg::S_EMIT;
				end else if (cnt_q == CNT_END) begin
					res_load = 1'b1;
					state_d  = mpt_pkg::S_EMIT;
					if (req_q != mpt_pkg::REQ_REGISTER && manual_q) begin
						res_d.status = mpt_pkg::STS_NOT_LEARNED;
					end else if (!free_found_q) begin
						res_d.status = mpt_pkg::STS_FULL;
					end else begin
						wr_data     = '0;
						wr_data.mac = mac_q;
						if (req_q == mpt_pkg::REQ_TRAFFIC) begin
							wr_data.ip   = ip_q;
							wr_data.last = now_q;
						end else if (req_q == mpt_pkg::REQ_ARP) begin
							wr_data.ip  = ip_q;
							wr_data.arp = mpt_pkg::ARP_FULL;
						end
						wr_en        = 1'b1;
						wr_addr      = free_idx_q;
						set_valid    = 1'b1;
						res_d.status = mpt_pkg::STS_INSERTED;
						res_d.idx    = 6'(free_idx_q);
						res_d.vld    = 1'b1;
						res_d.ent    = wr_data;
					end
				end
			end

			mpt_pkg::S_EMIT: begin
				if (emit_go) begin
					state_d = mpt_pkg::S_IDLE;
				end
			end

			default: state_d = mpt_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mpt_pkg::S_IDLE;
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			free_found_q <= 1'b0;
			out_vld_q    <= 1'b0;
			manual_q     <= 1'b0;
			valid_q      <= '0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			vld_s1       <= issue;
			free_found_q <= free_found_d;
			if (cfg_valid && cfg_ready) begin
				manual_q <= cfg_data;
			end
			if (clr_all) begin
				valid_q <= '0;
			end else if (set_valid) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (state_q == mpt_pkg::S_EMIT && emit_go) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_q <= s_axis_tuser;
			mac_q <= in_mac;
			ip_q  <= in_ip;
			now_q <= in_now;
			rs_q  <= in_slot;
		end
		addr_s1    <= issue_idx;
		free_idx_q <= free_idx_d;
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == mpt_pkg::S_EMIT && emit_go) begin
			out_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {7'd0, out_q.ent.arp, out_q.ent.last, out_q.ent.ip,
	                        out_q.ent.mac, out_q.vld, out_q.idx};

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_axis_tuser == mpt_pkg::REQ_FLUSH) |=> (valid_q == '0))
		else $error("flush did not clear the valid marks");

	a_write_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (state_q == mpt_pkg::S_EMIT))
		else $error("table write not followed by result emit");

	a_insert_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == mpt_pkg::STS_INSERTED) |-> m_axis_tdata[6])
		else $error("inserted result reports an empty slot");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_END)
		else $error("scan counter past table depth");

endmodule

/* src/mpt_entry_ram.sv */
// ---------------------------------------------------------------------------
// mpt_entry_ram: entry store of the MAC presence table
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module mpt_entry_ram #(
	parameter int TABLE_DEPTH = mpt_pkg::DEFAULT_TABLE_DEPTH,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [IDX_W-1:0]       wr_addr,
	input  mpt_pkg::entry_t        wr_data,
	input  logic [IDX_W-1:0]       rd_addr,
	output mpt_pkg::entry_t        rd_data
);
	mpt_pkg::entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
